// File: rtl/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared types, codes and helpers for the latest-frame slot manager.
// ----------------------------------------------------------------------------
package lfsm_pkg;

    localparam int unsigned CNT_W    = 32;
    localparam int unsigned DIM_W    = 16;
    localparam int unsigned PITCH_W  = 17;
    localparam int unsigned OFFSET_W = 33;
    localparam int unsigned SEQ_W    = 32;

    typedef enum logic [1:0] {
        CMD_PUBLISH = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_READY     = 2'd1,
        SLOT_DISPLAYED = 2'd2
    } slot_state_t;

    typedef enum logic [3:0] {
        STS_PUBLISHED    = 4'd0,
        STS_REPLACED     = 4'd1,
        STS_TAKEN        = 4'd2,
        STS_RELEASED     = 4'd3,
        STS_UNCONFIGURED = 4'd4,
        STS_NO_SOURCE    = 4'd5,
        STS_PITCH_NARROW = 4'd6,
        STS_DROPPED      = 4'd7,
        STS_NONE_READY   = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_MUL,
        ST_FINISH
    } fsm_state_t;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// File: rtl/lfsm_offset_unit.sv
// ----------------------------------------------------------------------------
// lfsm_offset_unit
// Two-stage slot offset multiplier: slot * pitch, then times height.
// ----------------------------------------------------------------------------
module lfsm_offset_unit #(
    parameter int unsigned IDX_W = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [IDX_W-1:0]                   slot,
    input  logic [lfsm_pkg::PITCH_W-1:0]       pitch,
    input  logic [lfsm_pkg::DIM_W-1:0]         height,
    output logic                               done,
    output logic [lfsm_pkg::OFFSET_W-1:0]      offset
);

    localparam int unsigned P1_W = IDX_W + lfsm_pkg::PITCH_W;
    localparam int unsigned P2_W = P1_W + lfsm_pkg::DIM_W;

    logic                          stage1_valid_reg;
    logic                          stage2_valid_reg;
    logic [P1_W-1:0]               prod1_reg;
    logic [lfsm_pkg::DIM_W-1:0]    height_reg;
    logic [P2_W-1:0]               prod2;
    logic [lfsm_pkg::OFFSET_W-1:0] offset_reg;

    assign prod2 = P2_W'(prod1_reg) * P2_W'(height_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_valid_reg <= 1'b0;
            stage2_valid_reg <= 1'b0;
        end else begin
            stage1_valid_reg <= start;
            stage2_valid_reg <= stage1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod1_reg  <= P1_W'(slot) * P1_W'(pitch);
            height_reg <= height;
        end
        if (stage1_valid_reg) begin
            offset_reg <= prod2[lfsm_pkg::OFFSET_W-1:0];
        end
    end

    assign done   = stage2_valid_reg;
    assign offset = offset_reg;

endmodule

// File: rtl/latest_frame_slot_manager.sv
// ----------------------------------------------------------------------------
// latest_frame_slot_manager
// Triple-buffer style bookkeeping: publish, take newest, release displayed.
// ----------------------------------------------------------------------------
// Accepted requests go ST_SCAN, ST_EXEC, ST_MUL (offset multiply, only when a
// slot is returned), ST_FINISH. One slot is compared per cycle by a shared
// sequence comparator; a new request is accepted only back in ST_IDLE.
// Reset (aresetn low, synchronous): all slots free, sequence and counters
// zero, frame width and height zero (unconfigured). A register write also
// frees all slots and clears the sequence and counters.
// ----------------------------------------------------------------------------
module latest_frame_slot_manager #(
    parameter int unsigned SLOT_COUNT = 3
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write port
    input  logic         cfg_wr_en,
    input  logic [0:0]   cfg_index,
    input  logic [15:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // source_present[0], source_pitch[16:1], zero pad
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot_index[1:0], slot_offset[34:2], row_pitch[51:35], ready_slots[53:52],
    // displayed_slots[55:54], published_total[87:56], replaced_total[119:88],
    // dropped_total[151:120], refused_total[183:152], leased_total[215:184]
    output logic [215:0] m_tdata,
    output logic [3:0]   m_tuser    // status[3:0]
);

    localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
    localparam int unsigned NUM_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    // configuration
    logic [lfsm_pkg::DIM_W-1:0]   frame_width_reg;
    logic [lfsm_pkg::DIM_W-1:0]   frame_height_reg;
    logic                         configured;
    logic [lfsm_pkg::PITCH_W-1:0] pitch;

    // slot pool
    lfsm_pkg::slot_state_t        slot_status_reg [SLOT_COUNT];
    logic [lfsm_pkg::SEQ_W-1:0]   slot_seq_reg    [SLOT_COUNT];
    logic [lfsm_pkg::SEQ_W-1:0]   last_seq_reg;
    logic [lfsm_pkg::CNT_W-1:0]   cnt_published_reg;
    logic [lfsm_pkg::CNT_W-1:0]   cnt_replaced_reg;
    logic [lfsm_pkg::CNT_W-1:0]   cnt_dropped_reg;
    logic [lfsm_pkg::CNT_W-1:0]   cnt_refused_reg;
    logic [lfsm_pkg::CNT_W-1:0]   cnt_leased_reg;

    // current transaction
    lfsm_pkg::fsm_state_t         state_reg;
    lfsm_pkg::fsm_state_t         state_next;
    lfsm_pkg::cmd_t               cmd_reg;
    logic                         present_reg;
    logic [lfsm_pkg::DIM_W-1:0]   src_pitch_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         free_found_reg;
    logic [IDX_W-1:0]             free_idx_reg;
    logic                         best_valid_reg;
    logic [IDX_W-1:0]             best_idx_reg;
    logic [lfsm_pkg::SEQ_W-1:0]   best_seq_reg;
    logic [NUM_W-1:0]             ready_num_reg;
    logic [NUM_W-1:0]             disp_num_reg;
    lfsm_pkg::status_t            res_status_reg;
    logic [IDX_W-1:0]             res_slot_reg;
    logic [lfsm_pkg::OFFSET_W-1:0] res_offset_reg;

    // result register
    logic                          m_valid_reg;
    lfsm_pkg::status_t             out_status_reg;
    logic [1:0]                    out_slot_reg;
    logic [lfsm_pkg::OFFSET_W-1:0] out_offset_reg;
    logic [lfsm_pkg::PITCH_W-1:0]  out_pitch_reg;
    logic [1:0]                    out_ready_reg;
    logic [1:0]                    out_disp_reg;
    logic [lfsm_pkg::CNT_W-1:0]    out_published_reg;
    logic [lfsm_pkg::CNT_W-1:0]    out_replaced_reg;
    logic [lfsm_pkg::CNT_W-1:0]    out_dropped_reg;
    logic [lfsm_pkg::CNT_W-1:0]    out_refused_reg;
    logic [lfsm_pkg::CNT_W-1:0]    out_leased_reg;

    // shared comparator and scan view
    lfsm_pkg::slot_state_t        cur_status;
    logic [lfsm_pkg::SEQ_W-1:0]   cur_seq;
    logic [lfsm_pkg::SEQ_W-1:0]   cmp_a;
    logic [lfsm_pkg::SEQ_W-1:0]   cmp_b;
    logic                         cmp_lt;
    logic                         take_best;

    // exec decisions
    lfsm_pkg::status_t            exec_status;
    logic [IDX_W-1:0]             exec_slot;
    logic                         exec_has_slot;
    logic [lfsm_pkg::SEQ_W-1:0]   next_seq;

    // control
    logic                         in_fire;
    logic                         out_load;
    logic                         mul_start;
    logic                         mul_done;
    logic [lfsm_pkg::OFFSET_W-1:0] mul_offset;

    assign configured = (frame_width_reg != '0) && (frame_height_reg != '0);
    assign pitch = configured ?
        ((lfsm_pkg::PITCH_W'(frame_width_reg) + lfsm_pkg::PITCH_W'(3)) &
         ~lfsm_pkg::PITCH_W'(3)) : '0;

    assign cur_status = slot_status_reg[idx_reg];
    assign cur_seq    = slot_seq_reg[idx_reg];

    // publish looks for the oldest ready tag, take for the newest
    always_comb begin
        if (cmd_reg == lfsm_pkg::CMD_PUBLISH) begin
            cmp_a = cur_seq;
            cmp_b = best_seq_reg;
        end else begin
            cmp_a = best_seq_reg;
            cmp_b = cur_seq;
        end
    end
    assign cmp_lt    = cmp_a < cmp_b;
    assign take_best = (cur_status == lfsm_pkg::SLOT_READY) && (!best_valid_reg || cmp_lt);

    assign next_seq = lfsm_pkg::sat_inc(last_seq_reg);

    always_comb begin
        exec_status   = lfsm_pkg::STS_RELEASED;
        exec_slot     = best_idx_reg;
        exec_has_slot = 1'b0;
        case (cmd_reg)
            lfsm_pkg::CMD_PUBLISH: begin
                if (!configured) begin
                    exec_status = lfsm_pkg::STS_UNCONFIGURED;
                end else if (!present_reg) begin
                    exec_status = lfsm_pkg::STS_NO_SOURCE;
                end else if (src_pitch_reg < frame_width_reg) begin
                    exec_status = lfsm_pkg::STS_PITCH_NARROW;
                end else if (free_found_reg) begin
                    exec_status   = lfsm_pkg::STS_PUBLISHED;
                    exec_slot     = free_idx_reg;
                    exec_has_slot = 1'b1;
                end else if (best_valid_reg) begin
                    exec_status   = lfsm_pkg::STS_REPLACED;
                    exec_has_slot = 1'b1;
                end else begin
                    exec_status = lfsm_pkg::STS_DROPPED;
                end
            end
            lfsm_pkg::CMD_TAKE: begin
                if (!configured) begin
                    exec_status = lfsm_pkg::STS_UNCONFIGURED;
                end else if (!best_valid_reg) begin
                    exec_status = lfsm_pkg::STS_NONE_READY;
                end else begin
                    exec_status   = lfsm_pkg::STS_TAKEN;
                    exec_has_slot = 1'b1;
                end
            end
            default: begin
                exec_status = lfsm_pkg::STS_RELEASED;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lfsm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = lfsm_pkg::ST_SCAN;
                end
            end
            lfsm_pkg::ST_SCAN: begin
                if (idx_reg == LAST_IDX) begin
                    state_next = lfsm_pkg::ST_EXEC;
                end
            end
            lfsm_pkg::ST_EXEC: begin
                state_next = exec_has_slot ? lfsm_pkg::ST_MUL : lfsm_pkg::ST_FINISH;
            end
            lfsm_pkg::ST_MUL: begin
                if (mul_done) begin
                    state_next = lfsm_pkg::ST_FINISH;
                end
            end
            lfsm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = lfsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfsm_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            lfsm_pkg::ST_IDLE:   s_tready  = 1'b1;
            lfsm_pkg::ST_EXEC:   mul_start = exec_has_slot;
            lfsm_pkg::ST_FINISH: out_load  = !m_valid_reg || m_tready;
            default: begin
                s_tready  = 1'b0;
                mul_start = 1'b0;
                out_load  = 1'b0;
            end
        endcase
    end

    assign in_fire = s_tvalid && s_tready;

    lfsm_offset_unit #(
        .IDX_W (IDX_W)
    ) u_offset (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .slot    (exec_slot),
        .pitch   (pitch),
        .height  (frame_height_reg),
        .done    (mul_done),
        .offset  (mul_offset)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfsm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration, pool and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg   <= '0;
            frame_height_reg  <= '0;
            last_seq_reg      <= '0;
            cnt_published_reg <= '0;
            cnt_replaced_reg  <= '0;
            cnt_dropped_reg   <= '0;
            cnt_refused_reg   <= '0;
            cnt_leased_reg    <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_status_reg[i] <= lfsm_pkg::SLOT_FREE;
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == lfsm_pkg::REG_FRAME_WIDTH) begin
                frame_width_reg <= cfg_wdata;
            end else begin
                frame_height_reg <= cfg_wdata;
            end
            last_seq_reg      <= '0;
            cnt_published_reg <= '0;
            cnt_replaced_reg  <= '0;
            cnt_dropped_reg   <= '0;
            cnt_refused_reg   <= '0;
            cnt_leased_reg    <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_status_reg[i] <= lfsm_pkg::SLOT_FREE;
            end
        end else if (state_reg == lfsm_pkg::ST_EXEC) begin
            case (exec_status)
                lfsm_pkg::STS_PUBLISHED, lfsm_pkg::STS_REPLACED: begin
                    last_seq_reg               <= next_seq;
                    slot_seq_reg[exec_slot]    <= next_seq;
                    slot_status_reg[exec_slot] <= lfsm_pkg::SLOT_READY;
                    cnt_published_reg <= lfsm_pkg::sat_inc(cnt_published_reg);
                    if (exec_status == lfsm_pkg::STS_REPLACED) begin
                        cnt_replaced_reg <= lfsm_pkg::sat_inc(cnt_replaced_reg);
                    end
                end
                lfsm_pkg::STS_TAKEN: begin
                    slot_status_reg[exec_slot] <= lfsm_pkg::SLOT_DISPLAYED;
                    cnt_leased_reg <= lfsm_pkg::sat_inc(cnt_leased_reg);
                end
                lfsm_pkg::STS_RELEASED: begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (slot_status_reg[i] == lfsm_pkg::SLOT_DISPLAYED) begin
                            slot_status_reg[i] <= lfsm_pkg::SLOT_FREE;
                        end
                    end
                end
                lfsm_pkg::STS_DROPPED: begin
                    cnt_dropped_reg <= lfsm_pkg::sat_inc(cnt_dropped_reg);
                end
                default: begin
                    cnt_refused_reg <= lfsm_pkg::sat_inc(cnt_refused_reg);
                end
            endcase
        end
    end

    // transaction datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lfsm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    cmd_reg        <= lfsm_pkg::cmd_t'(s_tuser[1:0]);
                    present_reg    <= s_tdata[0];
                    src_pitch_reg  <= s_tdata[16:1];
                    idx_reg        <= '0;
                    free_found_reg <= 1'b0;
                    free_idx_reg   <= '0;
                    best_valid_reg <= 1'b0;
                    best_idx_reg   <= '0;
                    best_seq_reg   <= '0;
                    ready_num_reg  <= '0;
                    disp_num_reg   <= '0;
                end
            end
            lfsm_pkg::ST_SCAN: begin
                idx_reg <= idx_reg + 1'b1;
                if (cur_status == lfsm_pkg::SLOT_READY) begin
                    ready_num_reg <= ready_num_reg + 1'b1;
                end
                if (cur_status == lfsm_pkg::SLOT_DISPLAYED) begin
                    disp_num_reg <= disp_num_reg + 1'b1;
                end
                if (cur_status == lfsm_pkg::SLOT_FREE && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (take_best) begin
                    best_valid_reg <= 1'b1;
                    best_idx_reg   <= idx_reg;
                    best_seq_reg   <= cur_seq;
                end
            end
            lfsm_pkg::ST_EXEC: begin
                res_status_reg <= exec_status;
                res_slot_reg   <= exec_has_slot ? exec_slot : '0;
                res_offset_reg <= '0;
                case (exec_status)
                    lfsm_pkg::STS_PUBLISHED: ready_num_reg <= ready_num_reg + 1'b1;
                    lfsm_pkg::STS_TAKEN: begin
                        ready_num_reg <= ready_num_reg - 1'b1;
                        disp_num_reg  <= disp_num_reg + 1'b1;
                    end
                    lfsm_pkg::STS_RELEASED: disp_num_reg <= '0;
                    default: begin
                        ready_num_reg <= ready_num_reg;
                    end
                endcase
            end
            lfsm_pkg::ST_MUL: begin
                if (mul_done) begin
                    res_offset_reg <= mul_offset;
                end
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg    <= res_status_reg;
            out_slot_reg      <= 2'(res_slot_reg);
            out_offset_reg    <= res_offset_reg;
            out_pitch_reg     <= pitch;
            out_ready_reg     <= 2'(ready_num_reg);
            out_disp_reg      <= 2'(disp_num_reg);
            out_published_reg <= cnt_published_reg;
            out_replaced_reg  <= cnt_replaced_reg;
            out_dropped_reg   <= cnt_dropped_reg;
            out_refused_reg   <= cnt_refused_reg;
            out_leased_reg    <= cnt_leased_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_leased_reg, out_refused_reg, out_dropped_reg, out_replaced_reg,
                       out_published_reg, out_disp_reg, out_ready_reg, out_pitch_reg,
                       out_offset_reg, out_slot_reg};

endmodule
